// ----- rtl/ipv4_prefix_bucket_table_top_defines.svh -----
// Assertion macros used by the prefix table controller.
// Each use names the check and gives its property; clk and rst of the module are used.
`ifndef IPV4_PREFIX_BUCKET_TABLE_TOP_DEFINES_SVH
`define IPV4_PREFIX_BUCKET_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IPBT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipbt check failed");
`define IPBT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipbt check failed");
`else
`define IPBT_ASSERT(lbl, prop)
`define IPBT_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ----- rtl/ipbt_pkg.sv -----
package ipbt_pkg;

  localparam int ADDR_W                 = 32;
  localparam int COUNT_W                = 32;
  localparam int NUM_BUCKETS            = 256;
  localparam int BUCKET_W               = 8;
  localparam int PLEN_W                 = 5;
  localparam int ENTRY_W                = PLEN_W + ADDR_W;
  localparam int DEF_ENTRIES_PER_BUCKET = 32;
  localparam int S_TDATA_W              = ADDR_W + COUNT_W;
  localparam int S_TUSER_W              = 2;
  localparam int M_TDATA_W              = 8;
  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Operation carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_COMMIT = 2'd3
  } ipbt_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_FULL   = 2'd2
  } ipbt_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         capture;
    logic         fill_rd;
    logic         scan_start;
    logic         scan_issue;
    logic         ins_write;
    logic         clr_start;
    logic         clr_write;
    logic         commit;
    logic         out_load;
    logic         res_hit;
    ipbt_status_t res_status;
  } ipbt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    ipbt_op_t op;
    logic     bad_count;
    logic     fill_full;
    logic     match;
    logic     scan_more;
    logic     scan_done;
    logic     clr_last;
    logic     clr_wrap;
  } ipbt_sts_t;

  // Network mask for a prefix length; length zero gives an empty mask.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [5:0] sh;
    sh = 6'd32 - {1'b0, plen};
    if (plen == '0) begin
      return '0;
    end
    return ALL_ONES << sh;
  endfunction

endpackage

// ----- rtl/ipv4_prefix_bucket_table_top.sv -----
// IPv4 prefix table with 256 buckets keyed by the first address octet and two banks:
// inserts and clears go to the shadow bank, lookups read the active bank, and a commit
// swaps the two. An item is taken only while the block is idle; a lookup adds a bucket
// scan through the single read port of the prefix store, which yields one entry per
// cycle. The scan stops at the first matching entry. A clear walks the 256 shadow fill
// counts one per cycle through the single write port of the fill memory. A result
// waits in the output register and does not stop the next item from being taken.
// After reset a clearing pass zeroes the fill counts of both banks, and no beat is
// taken until it is done.
module ipv4_prefix_bucket_table_top
  import ipbt_pkg::*;
#(
  parameter int ENTRIES_PER_BUCKET = DEF_ENTRIES_PER_BUCKET
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // address [31:0], host_count [63:32]
  input  logic [S_TUSER_W-1:0] s_tuser,  // cmd [1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // hit [0], status [2:1], zero [7:3]
);

  ipbt_cmd_t cmd;
  ipbt_sts_t sts;

  // Sequencer.
  ipbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, bank flag and result register.
  ipbt_dp #(
    .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

endmodule

// ----- rtl/ipbt_ctrl.sv -----
`include "ipv4_prefix_bucket_table_top_defines.svh"

module ipbt_ctrl
  import ipbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  ipbt_sts_t sts,
  output ipbt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_FILL,
    ST_EXEC,
    ST_SCAN,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  state_t       state;
  logic         out_valid;
  logic         res_hit;
  ipbt_status_t res_status;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // Command decode for the datapath.
  always_comb begin
    cmd              = '0;
    cmd.capture      = s_tvalid && s_tready;
    cmd.fill_rd      = (state == ST_RD_FILL);
    cmd.scan_start   = (state == ST_EXEC);
    cmd.scan_issue   = (state == ST_SCAN) && !sts.match && sts.scan_more;
    cmd.ins_write    = (state == ST_EXEC) && (sts.op == CMD_INSERT) &&
                       !sts.bad_count && !sts.fill_full;
    cmd.clr_start    = (state == ST_EXEC) && (sts.op == CMD_CLEAR);
    cmd.clr_write    = (state == ST_INIT) || (state == ST_CLEAR);
    cmd.commit       = (state == ST_EXEC) && (sts.op == CMD_COMMIT);
    cmd.out_load     = (state == ST_RESULT) && (!out_valid || m_tready);
    cmd.res_hit      = res_hit;
    cmd.res_status   = res_status;
  end

  // Sequencer and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      out_valid  <= 1'b0;
      res_hit    <= 1'b0;
      res_status <= STATUS_OK;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          if (sts.clr_wrap) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_RD_FILL;
          end
        end
        ST_RD_FILL: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          res_hit <= 1'b0;
          unique case (sts.op)
            CMD_LOOKUP: begin
              res_status <= STATUS_OK;
              state      <= ST_SCAN;
            end
            CMD_INSERT: begin
              if (sts.bad_count) begin
                res_status <= STATUS_REJECT;
              end else if (sts.fill_full) begin
                res_status <= STATUS_FULL;
              end else begin
                res_status <= STATUS_OK;
              end
              state <= ST_RESULT;
            end
            CMD_CLEAR: begin
              res_status <= STATUS_OK;
              state      <= ST_CLEAR;
            end
            CMD_COMMIT: begin
              res_status <= STATUS_OK;
              state      <= ST_RESULT;
            end
          endcase
        end
        ST_SCAN: begin
          if (sts.match) begin
            res_hit <= 1'b1;
            state   <= ST_RESULT;
          end else if (sts.scan_done) begin
            state <= ST_RESULT;
          end
        end
        ST_CLEAR: begin
          if (sts.clr_last) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted beat always starts with the fill read.
  `IPBT_ASSERT(a_accept_to_fill, cmd.capture |=> (state == ST_RD_FILL))
  // Only lookups ever scan a bucket.
  `IPBT_ASSERT_IMPL(a_scan_is_lookup, state == ST_SCAN, sts.op == CMD_LOOKUP)
  // A store read just issued is still awaiting its compare, so the scan is not over.
  `IPBT_ASSERT(a_issue_pending, cmd.scan_issue |=> !sts.scan_done)
  // A hit is only ever reported for a lookup.
  `IPBT_ASSERT_IMPL(a_hit_lookup, (state == ST_RESULT) && res_hit, sts.op == CMD_LOOKUP)

endmodule

// ----- rtl/ipbt_dp.sv -----
module ipbt_dp
  import ipbt_pkg::*;
#(
  parameter int ENTRIES_PER_BUCKET = DEF_ENTRIES_PER_BUCKET
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  ipbt_cmd_t            cmd,
  output ipbt_sts_t            sts,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int FW          = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int IW          = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int FILL_DEPTH  = 2 * NUM_BUCKETS;
  localparam int FA_W        = 1 + BUCKET_W;
  localparam int STORE_DEPTH = FILL_DEPTH << IW;

  // Captured item.
  ipbt_op_t            op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [COUNT_W-1:0]  count_q;

  logic                active_bank;
  logic                fill_bank;
  logic [BUCKET_W-1:0] bucket;
  logic [FA_W-1:0]     fill_addr;

  // Fill counts per bank and bucket, zeroed by clearing passes.
  logic [FW-1:0]         fill_mem [FILL_DEPTH];
  logic [FW-1:0]         fill_rd_q;
  logic [FW-1:0]         fill_eff;
  logic [FA_W-1:0]       clr_addr;

  // Prefix store and scan state.
  logic [ENTRY_W-1:0]  store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]  entry_q;
  logic [FW-1:0]       idx;
  logic                rd_pend;

  logic [PLEN_W-1:0]   k;
  logic [PLEN_W-1:0]   plen;
  logic [ADDR_W-1:0]   net;
  logic                bad_count;
  logic                hit_q;
  ipbt_status_t        status_q;

  assign bucket    = addr_q[ADDR_W-1 -: BUCKET_W];
  assign fill_bank = (op_q == CMD_LOOKUP) ? active_bank : ~active_bank;
  assign fill_addr = {fill_bank, bucket};
  assign fill_eff  = fill_rd_q;

  // Capture of the input beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= ipbt_op_t'(s_tuser);
      addr_q  <= s_tdata[ADDR_W-1:0];
      count_q <= s_tdata[S_TDATA_W-1:ADDR_W];
    end
  end

  // Host count check and prefix length from the set bit position.
  always_comb begin
    k = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (count_q[i]) begin
        k = k | PLEN_W'(i);
      end
    end
    bad_count = (count_q < COUNT_W'(2)) || ((count_q & (count_q - COUNT_W'(1))) != '0);
    plen      = PLEN_W'(6'd32 - {1'b0, k});
    net       = addr_q & prefix_mask(plen);
  end

  // Bank select flag and clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      clr_addr    <= '0;
    end else begin
      if (cmd.commit) begin
        active_bank <= ~active_bank;
      end
      if (cmd.clr_start) begin
        clr_addr <= {~active_bank, BUCKET_W'(0)};
      end else if (cmd.clr_write) begin
        clr_addr <= clr_addr + FA_W'(1);
      end
    end
  end

  // Fill count memory: one read, one write port.
  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      fill_rd_q <= fill_mem[fill_addr];
    end
    if (cmd.clr_write) begin
      fill_mem[clr_addr] <= '0;
    end else if (cmd.ins_write) begin
      fill_mem[fill_addr] <= fill_eff + FW'(1);
    end
  end

  // Prefix store: insert write and scan read.
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      store_mem[{fill_addr, fill_eff[IW-1:0]}] <= {plen, net};
    end
    if (cmd.scan_issue) begin
      entry_q <= store_mem[{fill_addr, idx[IW-1:0]}];
    end
  end

  // Scan index and read-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_issue;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_issue) begin
      idx <= idx + FW'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.op        = op_q;
    sts.bad_count = bad_count;
    sts.fill_full = (fill_eff >= FW'(ENTRIES_PER_BUCKET));
    sts.match     = rd_pend &&
                    ((addr_q & prefix_mask(entry_q[ENTRY_W-1:ADDR_W])) ==
                     entry_q[ADDR_W-1:0]);
    sts.scan_more = (idx < fill_eff);
    sts.scan_done = (idx == fill_eff) && !rd_pend;
    sts.clr_last  = (clr_addr[BUCKET_W-1:0] == '1);
    sts.clr_wrap  = (clr_addr == '1);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit_q    <= cmd.res_hit;
      status_q <= cmd.res_status;
    end
  end

  assign m_tdata = {(M_TDATA_W - 3)'(0), status_q, hit_q};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ipbt_pkg::*;

  localparam int EPB          = DEF_ENTRIES_PER_BUCKET;
  localparam int RANDOM_ITEMS = 1525;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 2 * EPB + 16;

  // One stored result expectation.
  typedef struct {
    ipbt_op_t     op;
    logic         hit;
    ipbt_status_t status;
  } table_result_t;

  // A prefix that was offered for insertion, kept to aim lookups at it.
  typedef struct {
    bit [31:0]   addr;
    int unsigned k;
  } prefix_pick_t;

  // Shadow copy of the two-bank prefix table and the queue of results it predicts.
  class prefix_table_scoreboard;
    bit [PLEN_W-1:0] plen_mem [2][NUM_BUCKETS][EPB];
    bit [ADDR_W-1:0] net_mem  [2][NUM_BUCKETS][EPB];
    int unsigned     fill_cnt [2][NUM_BUCKETS];
    bit              live_bank;
    table_result_t   pending_results[$];
    int unsigned     mismatch_count;

    function new();
      foreach (fill_cnt[b, i]) fill_cnt[b][i] = 0;
      live_bank      = 1'b0;
      mismatch_count = 0;
    endfunction

    function bit [ADDR_W-1:0] len_to_mask(bit [PLEN_W-1:0] plen);
      return ~(32'hFFFF_FFFF >> plen);
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
        $display("%0t MISMATCH: %s", $realtime, what);
      end
    endtask

    // Work out the result of one accepted input beat and update the table copy.
    function void note_beat(ipbt_op_t op, bit [31:0] addr, bit [31:0] count);
      bit [7:0]      bkt;
      bit            shadow;
      int unsigned   k;
      int unsigned   fill;
      bit [31:0]     msk;
      table_result_t res;
      bkt        = addr[31:24];
      shadow     = ~live_bank;
      res.op     = op;
      res.hit    = 1'b0;
      res.status = STATUS_OK;
      case (op)
        CMD_LOOKUP: begin
          for (int i = 0; i < fill_cnt[live_bank][bkt]; i++) begin
            if ((addr & len_to_mask(plen_mem[live_bank][bkt][i])) ==
                net_mem[live_bank][bkt][i]) begin
              res.hit = 1'b1;
            end
          end
        end
        CMD_INSERT: begin
          fill = fill_cnt[shadow][bkt];
          if (count < 2 || (count & (count - 1)) != 0) begin
            res.status = STATUS_REJECT;
          end else if (fill >= EPB) begin
            res.status = STATUS_FULL;
          end else begin
            k   = $clog2(count);
            msk = 32'hFFFF_FFFF << k;
            plen_mem[shadow][bkt][fill] = 32 - k;
            net_mem[shadow][bkt][fill]  = addr & msk;
            fill_cnt[shadow][bkt]       = fill + 1;
          end
        end
        CMD_CLEAR: begin
          for (int b = 0; b < NUM_BUCKETS; b++) fill_cnt[shadow][b] = 0;
        end
        default: begin
          live_bank = shadow;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    task check_beat(logic [M_TDATA_W-1:0] beat);
      table_result_t res;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", beat));
      end else begin
        res = pending_results.pop_front();
        if (beat[0] !== res.hit) begin
          report_mismatch($sformatf("%s: hit %b, expected %b", res.op.name(), beat[0],
                                    res.hit));
        end
        if (beat[2:1] !== res.status) begin
          report_mismatch($sformatf("%s: status %b, expected %s", res.op.name(),
                                    beat[2:1], res.status.name()));
        end
        if (beat[M_TDATA_W-1:3] !== '0) begin
          report_mismatch($sformatf("%s: padding bits %b not zero", res.op.name(),
                                    beat[M_TDATA_W-1:3]));
        end
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  prefix_table_scoreboard sb = new();

  int unsigned  items_sent  = 0;
  int unsigned  tx_idle_pct = 29;
  int unsigned  rx_idle_pct = 59;
  bit           rx_hold_req = 1'b0;
  bit           flooded     = 1'b0;
  prefix_pick_t inserted_prefixes[$];

  ipv4_prefix_bucket_table_top #(
    .ENTRIES_PER_BUCKET(EPB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("FAIL ipv4_prefix_bucket_table_top");
    $finish;
  end

  // Result side ready: random idling plus an occasional long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rst && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_beat(m_tdata);
    end
  end

  function automatic bit [31:0] good_count();
    return 32'h1 << $urandom_range(31, 1);
  endfunction

  function automatic bit [31:0] bad_count();
    bit [31:0] c;
    case ($urandom_range(3))
      0: c = 32'h0;
      1: c = 32'h1;
      default: begin
        c = $urandom;
        if ($countones(c) < 2) c = 32'h3 << $urandom_range(30);
      end
    endcase
    return c;
  endfunction

  // Offer one input beat and wait until it is taken.
  task automatic send_beat(ipbt_op_t op, bit [31:0] addr, bit [31:0] count);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {count, addr};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    sb.note_beat(op, addr, count);
  endtask

  // Insert with a remembered prefix so later lookups can aim at it.
  task automatic insert_prefix(bit [31:0] addr, bit [31:0] count);
    prefix_pick_t p;
    send_beat(CMD_INSERT, addr, count);
    if (count >= 2 && (count & (count - 1)) == 0) begin
      p.addr = addr;
      p.k    = $clog2(count);
      inserted_prefixes.push_back(p);
      if (inserted_prefixes.size() > 24) void'(inserted_prefixes.pop_front());
    end
  endtask

  // Lookup aimed at a recent prefix: inside it, just outside it, or anywhere.
  task automatic aimed_lookup();
    prefix_pick_t p;
    bit [31:0]    msk;
    bit [31:0]    a;
    int unsigned  sel;
    sel = $urandom_range(9);
    a   = $urandom;
    if (inserted_prefixes.size() != 0 && sel < 8) begin
      p   = inserted_prefixes[$urandom_range(inserted_prefixes.size() - 1)];
      msk = 32'hFFFF_FFFF << p.k;
      a   = (p.addr & msk) | (a & ~msk);
      a[31:24] = p.addr[31:24];
      if (sel >= 6) a = a ^ (32'h1 << $urandom_range(31, p.k));
    end
    send_beat(CMD_LOOKUP, a, $urandom);
  endtask

  // Pause the input until every expected result is back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random sequences: build-and-query runs, bucket floods and plain noise.
  task automatic run_random_phase(int unsigned last_item, bit with_hold);
    bit [7:0]    pool [4];
    int unsigned npool;
    int unsigned n;
    int unsigned kind;
    bit [7:0]    bkt;
    bit          held;
    held = 1'b0;
    while (items_sent < last_item) begin
      kind = flooded ? $urandom_range(99) : 60;
      if (kind < 60) begin
        // Refill the shadow bank around a few buckets, mostly publish it, then query.
        if ($urandom_range(1)) send_beat(CMD_CLEAR, $urandom, $urandom);
        npool = $urandom_range(4, 1);
        foreach (pool[i]) pool[i] = $urandom_range(255);
        n = $urandom_range(12, 1);
        repeat (n) begin
          insert_prefix({pool[$urandom_range(npool - 1)], 24'($urandom)},
                        ($urandom_range(9) == 0) ? bad_count() : good_count());
        end
        if ($urandom_range(9) != 0) send_beat(CMD_COMMIT, $urandom, $urandom);
        n = $urandom_range(16, 4);
        repeat (n) aimed_lookup();
      end else if (kind < 68) begin
        // Overfill one bucket; the receiver may stall while the input keeps coming.
        flooded = 1'b1;
        if (with_hold && !held) begin
          held        = 1'b1;
          rx_hold_req = 1'b1;
        end
        bkt = $urandom_range(255);
        n   = EPB + $urandom_range(4, 1);
        repeat (n) insert_prefix({bkt, 24'($urandom)}, good_count());
        send_beat(CMD_COMMIT, $urandom, $urandom);
        repeat (4) aimed_lookup();
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          send_beat(ipbt_op_t'($urandom_range(3)), $urandom,
                    $urandom_range(1) ? good_count() : $urandom);
        end
      end
    end
  endtask

  // Main stimulus.
  initial begin
    int unsigned chunk;
    chunk = RANDOM_ITEMS / 3;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lookup, rejected counts, extreme prefix lengths, bank swaps.
    send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(CMD_INSERT, 32'hC0A8_0117, 32'h0000_0000);
    send_beat(CMD_INSERT, 32'hC0A8_0117, 32'h0000_0001);
    send_beat(CMD_INSERT, 32'hC0A8_0117, 32'h0000_0003);
    send_beat(CMD_INSERT, 32'hC0A8_0117, 32'hFFFF_FFFF);
    insert_prefix(32'hC0A8_0117, 32'h0000_0100);
    insert_prefix(32'hFFFF_FFFF, 32'h0000_0002);
    insert_prefix(32'h8012_3456, 32'h8000_0000);
    // A /1 whose masked network leaves the bucket octet of the raw address.
    insert_prefix(32'h7F00_0000, 32'h8000_0000);
    send_beat(CMD_LOOKUP, 32'hC0A8_0155, 32'hFFFF_FFFF);
    send_beat(CMD_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'hC0A8_01FE, 32'h0);
    send_beat(CMD_LOOKUP, 32'hC0A8_0200, 32'h0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFD, 32'h0);
    send_beat(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_beat(CMD_LOOKUP, 32'h80FF_FFFF, 32'h0);
    send_beat(CMD_CLEAR, 32'h0, 32'h0);
    send_beat(CMD_COMMIT, 32'h0, 32'h0);
    send_beat(CMD_LOOKUP, 32'hC0A8_0101, 32'h0);
    // Back-to-back swap brings the filled bank back intact.
    send_beat(CMD_COMMIT, 32'h0, 32'h0);
    send_beat(CMD_LOOKUP, 32'hC0A8_0101, 32'h0);
    insert_prefix(32'h0000_0000, 32'h0001_0000);
    send_beat(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    run_random_phase(items_sent + chunk, 1'b1);
    wait_drained();

    tx_idle_pct = 59;
    rx_idle_pct = 29;
    run_random_phase(items_sent + chunk, 1'b0);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(items_sent + chunk, 1'b1);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("PASS ipv4_prefix_bucket_table_top");
    end else begin
      $display("FAIL ipv4_prefix_bucket_table_top");
    end
    $finish;
  end

endmodule
